FILE: hdl/lsc_pkg.sv
package lsc_pkg;

  localparam int SENSOR_COUNT = 6;
  localparam int MV_W         = 12;
  localparam int POS_STEP     = 100;
  localparam int POS_OFFSET   = 250;

  localparam logic [MV_W-1:0] MV_FULL_SCALE   = 12'd3300;
  localparam logic [MV_W-1:0] THRESHOLD_RESET = 12'd1500;

  // One lane's product is at most 250 * 3300, which needs 21 signed bits.
  localparam int PROD_W = 21;
  // The weighted sum over all lanes stays within +/-1485000.
  localparam int SUM_W  = 22;
  // The magnitude of the weighted sum.
  localparam int REM_W  = 21;
  // The total weight is at most 6 * 3300.
  localparam int WT_W   = 15;
  // The quotient magnitude never exceeds 250.
  localparam int Q_W    = 8;
  localparam int CNT_W  = 3;
  localparam int POS_W  = 9;

  typedef struct packed {
    logic                     det;
    logic [MV_W-1:0]          wt;
    logic signed [PROD_W-1:0] prod;
  } lane_t;

  typedef struct packed {
    logic             neg;
    logic [REM_W-1:0] rem;
    logic [WT_W-1:0]  den;
    logic [Q_W-1:0]   quo;
    logic [CNT_W-1:0] count;
    logic             found;
  } div_t;

endpackage

FILE: hdl/line_sensor_centroid.sv
// Pipeline: each input item passes the lane, merge, divider and output
// registers in turn; the pipeline holds up to 11 items.
// Throughput: one item per cycle unless in_stall is high; an 8-stage restoring
// divider, one quotient bit per stage, sets the depth of the pipeline. A held
// result stalls the input only once all 11 stages are full.
// Reset: rst_n is synchronous and active low; it empties the pipeline and
// sets the threshold register to 1500 mV.
module line_sensor_centroid (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel: one frame of sensor readings per item.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lsc_pkg::MV_W-1:0]         in_sample_s0,
  input  logic [lsc_pkg::MV_W-1:0]         in_sample_s1,
  input  logic [lsc_pkg::MV_W-1:0]         in_sample_s2,
  input  logic [lsc_pkg::MV_W-1:0]         in_sample_s3,
  input  logic [lsc_pkg::MV_W-1:0]         in_sample_s4,
  input  logic [lsc_pkg::MV_W-1:0]         in_sample_s5,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [lsc_pkg::POS_W-1:0] out_centroid_pos,
  output logic [lsc_pkg::CNT_W-1:0]        out_sensor_hits,
  output logic                             out_line_found,
  // Threshold register write port.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsc_pkg::MV_W-1:0]         cfg_threshold_mv
);

  // Stage 0 holds the lane registers, stage 1 the merged sums, stages 2
  // through 9 the divider, and the last stage the output register.
  localparam int NST     = lsc_pkg::Q_W + 3;
  localparam int ST_LANE = 0;
  localparam int ST_MRG  = 1;
  localparam int ST_DIV  = 2;
  localparam int ST_OUT  = NST - 1;

  logic [lsc_pkg::MV_W-1:0] threshold_r;
  logic [NST-1:0]           valid_r;
  logic [NST-1:0]           valid_nxt;
  logic [NST-1:0]           ready;

  logic [lsc_pkg::MV_W-1:0] samples [lsc_pkg::SENSOR_COUNT];
  lsc_pkg::lane_t           lanes   [lsc_pkg::SENSOR_COUNT];
  lsc_pkg::div_t            div_q   [lsc_pkg::Q_W+1];

  logic signed [lsc_pkg::POS_W-1:0] pos_r;
  logic signed [lsc_pkg::POS_W-1:0] pos_nxt;
  logic [lsc_pkg::CNT_W-1:0]        count_r;
  logic                             found_r;
  logic signed [lsc_pkg::POS_W-1:0] quo_ext;

  // The register is always ready; the user must write it only while the block idles (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= lsc_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_threshold_mv;
    end
  end

  // A stage can take a new item when it is empty or when its own item moves
  // on in the same cycle. Bubbles collapse, so input keeps flowing while a
  // finished result waits at the output.
  always_comb begin
    ready[ST_OUT] = !valid_r[ST_OUT] || !out_stall;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
    if (ready[ST_LANE]) begin
      valid_nxt[ST_LANE] = in_valid;
    end else begin
      valid_nxt[ST_LANE] = valid_r[ST_LANE];
    end
    for (int k = 1; k < NST; k++) begin
      if (ready[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  assign in_stall = !ready[ST_LANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign samples[0] = in_sample_s0;
  assign samples[1] = in_sample_s1;
  assign samples[2] = in_sample_s2;
  assign samples[3] = in_sample_s3;
  assign samples[4] = in_sample_s4;
  assign samples[5] = in_sample_s5;

  // Each lane saturates, thresholds and weights one sensor.
  for (genvar i = 0; i < lsc_pkg::SENSOR_COUNT; i++) begin : g_lane
    lsc_lane #(
      .LANE(i)
    ) u_lane (
      .clk      (clk),
      .en       (ready[ST_LANE]),
      .sample   (samples[i]),
      .threshold(threshold_r),
      .lane_r   (lanes[i])
    );
  end

  // The merge adds the lane products and weights, counts the detected sensors
  // and splits off the sign, so the divider works on magnitudes.
  lsc_merge u_merge (
    .clk  (clk),
    .en   (ready[ST_MRG]),
    .lanes(lanes),
    .div_r(div_q[0])
  );

  // Restoring division, most significant quotient bit first. The quotient
  // never exceeds 250, so eight bits suffice and the first remainder is
  // always below the divisor shifted by eight.
  for (genvar j = 0; j < lsc_pkg::Q_W; j++) begin : g_div
    lsc_div_stage #(
      .BIT(lsc_pkg::Q_W - 1 - j)
    ) u_div (
      .clk   (clk),
      .en    (ready[ST_DIV + j]),
      .div_in(div_q[j]),
      .div_r (div_q[j+1])
    );
  end

  // Truncation toward zero comes from dividing the magnitude and then
  // restoring the sign. With zero total weight the divider output is
  // meaningless, and the position is forced to zero.
  always_comb begin
    quo_ext = $signed({1'b0, div_q[lsc_pkg::Q_W].quo});
    if (!div_q[lsc_pkg::Q_W].found) begin
      pos_nxt = '0;
    end else if (div_q[lsc_pkg::Q_W].neg) begin
      pos_nxt = -quo_ext;
    end else begin
      pos_nxt = quo_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[ST_OUT]) begin
      pos_r   <= pos_nxt;
      count_r <= div_q[lsc_pkg::Q_W].count;
      found_r <= div_q[lsc_pkg::Q_W].found;
    end
  end

  assign out_valid        = valid_r[ST_OUT];
  assign out_centroid_pos = pos_r;
  assign out_sensor_hits  = count_r;
  assign out_line_found   = found_r;

  // A result always lies within the span of the outer sensors.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_centroid_pos >= -250 && out_centroid_pos <= 250))
    else $error("line position out of range");

  // Without any weight the position must be zero.
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_line_found) |-> (out_centroid_pos == 0))
    else $error("nonzero position without weight");

  // Weight implies at least one detected sensor, and never more than six.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sensor_hits <= 3'd6 &&
                   (!out_line_found || out_sensor_hits != 3'd0)))
    else $error("detected count inconsistent");

  // With the output side free, the pipeline never pushes back on input.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

FILE: hdl/lsc_lane.sv
module lsc_lane #(
  parameter int LANE = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [lsc_pkg::MV_W-1:0]    sample,
  input  logic [lsc_pkg::MV_W-1:0]    threshold,
  output lsc_pkg::lane_t              lane_r
);

  localparam logic signed [lsc_pkg::PROD_W-1:0] POS =
    lsc_pkg::PROD_W'(LANE * lsc_pkg::POS_STEP - lsc_pkg::POS_OFFSET);

  logic [lsc_pkg::MV_W-1:0] sat;
  lsc_pkg::lane_t           lane_nxt;

  always_comb begin
    sat = (sample > lsc_pkg::MV_FULL_SCALE) ? lsc_pkg::MV_FULL_SCALE : sample;
    lane_nxt.det = (sat >= threshold);
    lane_nxt.wt  = lane_nxt.det ? sat : '0;
    lane_nxt.prod = POS *
      $signed({{(lsc_pkg::PROD_W-lsc_pkg::MV_W){1'b0}}, lane_nxt.wt});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

FILE: hdl/lsc_merge.sv
module lsc_merge (
  input  logic           clk,
  input  logic           en,
  input  lsc_pkg::lane_t lanes [lsc_pkg::SENSOR_COUNT],
  output lsc_pkg::div_t  div_r
);

  logic signed [lsc_pkg::SUM_W-1:0] sum;
  logic [lsc_pkg::WT_W-1:0]         wt;
  logic [lsc_pkg::CNT_W-1:0]        cnt;
  logic signed [lsc_pkg::SUM_W-1:0] mag;
  lsc_pkg::div_t                    div_nxt;

  always_comb begin
    sum = '0;
    wt  = '0;
    cnt = '0;
    for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++) begin
      sum = sum + lsc_pkg::SUM_W'(lanes[i].prod);
      wt  = wt + lsc_pkg::WT_W'(lanes[i].wt);
      cnt = cnt + lsc_pkg::CNT_W'(lanes[i].det);
    end
    mag = (sum < 0) ? -sum : sum;
    div_nxt.neg   = (sum < 0);
    div_nxt.rem   = mag[lsc_pkg::REM_W-1:0];
    div_nxt.den   = wt;
    div_nxt.quo   = '0;
    div_nxt.count = cnt;
    div_nxt.found = (wt != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

endmodule

FILE: hdl/lsc_div_stage.sv
module lsc_div_stage #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  lsc_pkg::div_t div_in,
  output lsc_pkg::div_t div_r
);

  localparam int CMP_W = lsc_pkg::WT_W + lsc_pkg::Q_W;

  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] shifted;
  logic [CMP_W-1:0] diff;
  lsc_pkg::div_t    div_nxt;

  always_comb begin
    rem_ext = CMP_W'(div_in.rem);
    shifted = CMP_W'(div_in.den) << BIT;
    diff    = rem_ext - shifted;
    div_nxt = div_in;
    if (rem_ext >= shifted) begin
      div_nxt.rem      = diff[lsc_pkg::REM_W-1:0];
      div_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

endmodule

FILE: tb/line_sensor_centroid_tb.sv
module line_sensor_centroid_tb;

  // One frame of sensor readings, s0 first, as it crosses the input channel.
  typedef logic [lsc_pkg::MV_W-1:0] frame_t [lsc_pkg::SENSOR_COUNT];

  // What the block should answer for one frame.
  typedef struct {
    logic signed [lsc_pkg::POS_W-1:0] pos;
    logic [lsc_pkg::CNT_W-1:0]        count;
    logic                             found;
  } centroid_t;

  // The pipeline is 11 deep; SETTLE adds a margin on top for any slack at the outputs.
  localparam int PIPE_DEPTH  = 11;
  localparam int SETTLE      = PIPE_DEPTH + 4;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 14;

  // Keeps the threshold the block is running with and the answers still owed,
  // oldest first. Frames carry no state, so each answer depends only on its
  // frame and the threshold at the time the frame went in.
  class centroid_scoreboard;
    logic [lsc_pkg::MV_W-1:0] threshold;
    centroid_t                owed_q[$];
    int                       errors;
    int                       frames;
    int                       checked;

    function new();
      threshold = lsc_pkg::THRESHOLD_RESET;
    endfunction

    function centroid_t centroid_of(frame_t f);
      int        moment;
      int        weight;
      int        mv;
      int        hits;
      centroid_t r;
      moment = 0;
      weight = 0;
      hits   = 0;
      for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++) begin
        mv = int'(f[i]);
        if (mv > int'(lsc_pkg::MV_FULL_SCALE)) mv = int'(lsc_pkg::MV_FULL_SCALE);
        if (mv >= int'(threshold)) begin
          moment += (i * lsc_pkg::POS_STEP - lsc_pkg::POS_OFFSET) * mv;
          weight += mv;
          hits++;
        end
      end
      r.count = lsc_pkg::CNT_W'(hits);
      r.found = (weight > 0);
      // Integer division in SystemVerilog truncates toward zero, as required.
      r.pos   = lsc_pkg::POS_W'((weight > 0) ? moment / weight : 0);
      return r;
    endfunction

    function void note_frame(frame_t f);
      owed_q.push_back(centroid_of(f));
      frames++;
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_result(logic signed [lsc_pkg::POS_W-1:0] pos,
                      logic [lsc_pkg::CNT_W-1:0] count, logic found);
      centroid_t e;
      if (owed_q.size() == 0) begin
        report($sformatf("result pos=%0d count=%0d found=%0d with nothing owed",
                         pos, count, found));
      end else begin
        e = owed_q.pop_front();
        checked++;
        if (pos !== e.pos)
          report($sformatf("centroid position %0d, expected %0d", pos, e.pos));
        if (count !== e.count)
          report($sformatf("sensor hits %0d, expected %0d", count, e.count));
        if (found !== e.found)
          report($sformatf("line_found %0d, expected %0d", found, e.found));
      end
    endtask
  endclass

  // Every input of the block starts at a known value.
  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [lsc_pkg::MV_W-1:0]         in_sample_s0 = '0;
  logic [lsc_pkg::MV_W-1:0]         in_sample_s1 = '0;
  logic [lsc_pkg::MV_W-1:0]         in_sample_s2 = '0;
  logic [lsc_pkg::MV_W-1:0]         in_sample_s3 = '0;
  logic [lsc_pkg::MV_W-1:0]         in_sample_s4 = '0;
  logic [lsc_pkg::MV_W-1:0]         in_sample_s5 = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [lsc_pkg::POS_W-1:0] out_centroid_pos;
  logic [lsc_pkg::CNT_W-1:0]        out_sensor_hits;
  logic                             out_line_found;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [lsc_pkg::MV_W-1:0]         cfg_threshold_mv = '0;

  // While set, neither side idles, so the pipeline runs back to back.
  logic quiet = 1'b0;

  centroid_scoreboard sb = new();
  int settings_used = 0;
  int quiet_cycles = 0;

  line_sensor_centroid uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_s0       (in_sample_s0),
    .in_sample_s1       (in_sample_s1),
    .in_sample_s2       (in_sample_s2),
    .in_sample_s3       (in_sample_s3),
    .in_sample_s4       (in_sample_s4),
    .in_sample_s5       (in_sample_s5),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_centroid_pos   (out_centroid_pos),
    .out_sensor_hits    (out_sensor_hits),
    .out_line_found     (out_line_found),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_threshold_mv   (cfg_threshold_mv)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // The receiver holds off in about one cycle of seven, except in the quiet
  // stretch. All decisions are made at the edge, so the block sees the new
  // stall level before the next edge samples it.
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      quiet_cycles++;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Results are sampled at the edge, before any of this edge's updates land,
  // so what is checked is exactly what the handshake moved.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_centroid_pos, out_sensor_hits, out_line_found);
  end

  // Watchdog: any handshake on any channel resets the count of dead cycles.
  int dead_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  function automatic frame_t frame_of(int a, int b, int c, int d, int e, int f);
    frame_t r;
    r[0] = lsc_pkg::MV_W'(a);
    r[1] = lsc_pkg::MV_W'(b);
    r[2] = lsc_pkg::MV_W'(c);
    r[3] = lsc_pkg::MV_W'(d);
    r[4] = lsc_pkg::MV_W'(e);
    r[5] = lsc_pkg::MV_W'(f);
    return r;
  endfunction

  // Offers one frame and holds it until the block takes it. Idle cycles go in
  // before the frame, so valid is only ever assigned once per edge: either it
  // drops for an idle cycle or it carries the next frame straight on.
  task automatic send_frame(frame_t f);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_sample_s0 <= f[0];
    in_sample_s1 <= f[1];
    in_sample_s2 <= f[2];
    in_sample_s3 <= f[3];
    in_sample_s4 <= f[4];
    in_sample_s5 <= f[5];
    do @(posedge clk); while (in_stall);
    sb.note_frame(f);
  endtask

  // Lets the pipeline empty. Valid drops at once so the last frame is not
  // taken a second time. Every frame yields a result, so an empty queue of
  // owed answers already means the block is idle; the extra cycles are margin.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Changes the threshold only with nothing in flight.
  task automatic set_threshold(logic [lsc_pkg::MV_W-1:0] mv);
    wait_drained();
    cfg_valid        <= 1'b1;
    cfg_threshold_mv <= mv;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.threshold = mv;
    settings_used++;
  endtask

  // Random frames. Half look like a real line under the array: one bright
  // sensor, moderately lit neighbors and a dark background. The rest are
  // full-range noise, which also exercises every input bit and the clamp at
  // full scale, and frames built from the corner values around the threshold.
  task automatic send_random(int n);
    frame_t f;
    int     kind;
    int     center;
    int     span;
    int     thr;
    for (int k = 0; k < n; k++) begin
      kind   = int'($urandom_range(99));
      center = int'($urandom_range(lsc_pkg::SENSOR_COUNT - 1));
      thr    = int'(sb.threshold);
      for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++) begin
        span = (i > center) ? i - center : center - i;
        if (kind < 50) begin
          if (span == 0)      f[i] = lsc_pkg::MV_W'($urandom_range(4095, 2200));
          else if (span == 1) f[i] = lsc_pkg::MV_W'($urandom_range(3300, 700));
          else                f[i] = lsc_pkg::MV_W'($urandom_range(600));
          // Now and then a second, narrower line shows up.
          if ($urandom_range(9) == 0) f[i] = lsc_pkg::MV_W'($urandom_range(3300));
        end else if (kind < 80) begin
          f[i] = lsc_pkg::MV_W'($urandom_range(4095));
        end else begin
          case ($urandom_range(5))
            0: f[i] = '0;
            1: f[i] = lsc_pkg::MV_FULL_SCALE;
            2: f[i] = lsc_pkg::MV_W'((thr > 0) ? thr - 1 : 0);
            3: f[i] = lsc_pkg::MV_W'((thr < 4095) ? thr : 4095);
            4: f[i] = lsc_pkg::MV_W'((thr < 4095) ? thr + 1 : 4095);
            default: f[i] = lsc_pkg::MV_W'($urandom_range(4095, 3301));
          endcase
        end
      end
      send_frame(f);
    end
  endtask

  initial begin
    int thr;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames against the threshold left by reset (1500 mV).
    send_frame(frame_of(0, 0, 0, 0, 0, 0));                   // no line at all
    send_frame(frame_of(4095, 4095, 4095, 4095, 4095, 4095)); // all clamped
    send_frame(frame_of(3300, 3300, 3300, 3300, 3300, 3300)); // centered
    for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++) begin
      frame_t f;
      f    = frame_of(0, 0, 0, 0, 0, 0);
      f[i] = lsc_pkg::MV_FULL_SCALE;                           // each position alone
      send_frame(f);
    end
    send_frame(frame_of(1500, 1499, 1499, 1499, 1499, 1499)); // exactly at threshold
    send_frame(frame_of(0, 0, 0, 0, 0, 3301));                // just over full scale
    send_frame(frame_of(3300, 1500, 0, 0, 0, 0));             // negative, truncates up
    send_frame(frame_of(0, 0, 0, 0, 1500, 3300));             // positive, truncates down
    send_frame(frame_of(0, 0, 2000, 2000, 0, 0));             // two sensors, balanced
    send_frame(frame_of(0, 4000, 1600, 0, 0, 0));             // clamped next to a weak one
    send_frame(frame_of(2730, 1365, 2730, 1365, 2730, 1365)); // alternating bit patterns

    // Threshold at zero: every sensor counts, but zero readings carry no
    // weight, so the count can be six while no line is found.
    set_threshold(12'd0);
    send_frame(frame_of(0, 0, 0, 0, 0, 0));
    send_frame(frame_of(0, 0, 0, 0, 0, 1));
    send_random(50);

    // Threshold at full scale: only clamped or full-scale readings count.
    set_threshold(lsc_pkg::MV_FULL_SCALE);
    send_frame(frame_of(3299, 3300, 3299, 4095, 3299, 3299));
    send_frame(frame_of(3300, 3300, 3300, 3300, 3300, 3300));
    send_random(50);

    // Threshold above full scale: nothing can ever be detected.
    set_threshold(12'hFFF);
    send_frame(frame_of(4095, 4095, 4095, 4095, 4095, 4095));
    send_random(25);

    set_threshold(12'd1);
    send_random(40);

    // Several random settings; one of them runs with no idling on either side.
    for (int p = 0; p < 5; p++) begin
      thr = ($urandom_range(9) == 0) ? int'($urandom_range(4095))
                                     : int'($urandom_range(3300));
      set_threshold(lsc_pkg::MV_W'(thr));
      quiet = (p == 2);
      send_random(50);
      quiet = 1'b0;
    end

    set_threshold(lsc_pkg::THRESHOLD_RESET);
    send_random(40);

    wait_drained();
    while (sb.owed() != 0) begin
      sb.report("answer still owed at the end of the run");
      void'(sb.owed_q.pop_front());
    end

    $display("Ran %0d frames under %0d threshold writes; %0d results compared.",
             sb.frames, settings_used, sb.checked);
    $display("Back-to-back stretch lasted %0d cycles; %0d mismatches seen.",
             quiet_cycles, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
